// ----- rtl/tgpw_pkg.sv -----
// Shared types, constants and the glyph table of the text glyph pixel writer.
package tgpw_pkg;

  localparam int CFG_W     = 13;
  localparam int ADDR_W    = 24;
  localparam int PIX_W     = 16;
  localparam int CODE_W    = 8;
  localparam int GLYPH_W   = 7;
  localparam int ROW_W     = 3;
  localparam int FONT_AW   = GLYPH_W + ROW_W;
  localparam int CFG_AW    = 2;

  localparam logic [CODE_W-1:0] CHAR_NL    = 8'd10;
  localparam logic [ROW_W-1:0]  LAST_ROW   = 3'd5;
  localparam logic [ROW_W-1:0]  LAST_BIT   = 3'd5;
  localparam logic [ROW_W-1:0]  FLIP_BASE  = 3'd4;
  localparam logic [3:0]        CELL_W     = 4'd6;
  localparam logic [3:0]        LINE_H     = 4'd8;

  localparam logic [CFG_W-1:0] RST_SCREEN_WIDTH  = 13'd320;
  localparam logic [CFG_W-1:0] RST_SCREEN_HEIGHT = 13'd240;
  localparam logic [CFG_W-1:0] RST_ROW_PITCH     = 13'd320;

  typedef enum logic [CFG_AW-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_ROW_PITCH     = 2'd2
  } cfg_reg_e_t;

  typedef struct packed {
    logic [CFG_W-1:0] screen_width;
    logic [CFG_W-1:0] screen_height;
    logic [CFG_W-1:0] row_pitch_words;
  } cfg_regs_t;

  // Rows 0 to 5 of a glyph, row 0 in the top byte. Rows 6 and 7 are blank.
  function automatic logic [47:0] font_glyph(input logic [GLYPH_W-1:0] g);
    logic [47:0] v;
    case (g)
      7'd33:  v = 48'h303030003000;
      7'd34:  v = 48'h505000000000;
      7'd35:  v = 48'h50f850f85000;
      7'd36:  v = 48'h78a07028f000;
      7'd37:  v = 48'h881020408800;
      7'd38:  v = 48'h40a068906800;
      7'd39:  v = 48'h204000000000;
      7'd40:  v = 48'h204040402000;
      7'd41:  v = 48'h402020204000;
      7'd42:  v = 48'h20a870a82000;
      7'd43:  v = 48'h002070200000;
      7'd44:  v = 48'h000000602040;
      7'd45:  v = 48'h000070000000;
      7'd46:  v = 48'h000000606000;
      7'd47:  v = 48'h081020408000;
      7'd48:  v = 48'h70c8c8c87000;
      7'd49:  v = 48'h307030307800;
      7'd50:  v = 48'hf01870c0f800;
      7'd51:  v = 48'hf81830987000;
      7'd52:  v = 48'h3070d0f81000;
      7'd53:  v = 48'hf8c0f018f000;
      7'd54:  v = 48'h70c0f0c87000;
      7'd55:  v = 48'hf8183060c000;
      7'd56:  v = 48'h70c870c87000;
      7'd57:  v = 48'h70c878087000;
      7'd58:  v = 48'h606000606000;
      7'd59:  v = 48'h606000602040;
      7'd60:  v = 48'h102040201000;
      7'd61:  v = 48'h007000700000;
      7'd62:  v = 48'h402010204000;
      7'd63:  v = 48'h781830003000;
      7'd64:  v = 48'h70a8b8807000;
      7'd65:  v = 48'h70c8c8f8c800;
      7'd66:  v = 48'hf0c8f0c8f000;
      7'd67:  v = 48'h70c8c0c87000;
      7'd68:  v = 48'hf0c8c8c8f000;
      7'd69:  v = 48'hf8c0f0c0f800;
      7'd70:  v = 48'hf8c0f0c0c000;
      7'd71:  v = 48'h78c0d8c87800;
      7'd72:  v = 48'hc8c8f8c8c800;
      7'd73:  v = 48'h783030307800;
      7'd74:  v = 48'hf81818d87000;
      7'd75:  v = 48'hc8d0e0d0c800;
      7'd76:  v = 48'hc0c0c0c0f800;
      7'd77:  v = 48'hd8f8f8a88800;
      7'd78:  v = 48'hc8e8f8d8c800;
      7'd79:  v = 48'h70c8c8c87000;
      7'd80:  v = 48'hf0c8c8f0c000;
      7'd81:  v = 48'h70c8c8c87008;
      7'd82:  v = 48'hf0c8c8f0c800;
      7'd83:  v = 48'h78e07038f000;
      7'd84:  v = 48'h783030303000;
      7'd85:  v = 48'hc8c8c8c87000;
      7'd86:  v = 48'hc8c8c8702000;
      7'd87:  v = 48'h88a8f8f8d800;
      7'd88:  v = 48'hc8c870c8c800;
      7'd89:  v = 48'h686878303000;
      7'd90:  v = 48'hf83060c0f800;
      7'd91:  v = 48'h604040406000;
      7'd92:  v = 48'h804020100800;
      7'd93:  v = 48'h602020206000;
      7'd94:  v = 48'h205088000000;
      7'd95:  v = 48'h000000007800;
      7'd96:  v = 48'h402000000000;
      7'd97:  v = 48'h007898987800;
      7'd98:  v = 48'hc0f0c8c8f000;
      7'd99:  v = 48'h0078e0e07800;
      7'd100: v = 48'h187898987800;
      7'd101: v = 48'h0070d8e07000;
      7'd102: v = 48'h3860f8606000;
      7'd103: v = 48'h007098f81870;
      7'd104: v = 48'hc0f0c8c8c800;
      7'd105: v = 48'h300070307800;
      7'd106: v = 48'h180018189870;
      7'd107: v = 48'hc0c8f0c8c800;
      7'd108: v = 48'h606060603800;
      7'd109: v = 48'h00d0f8a8a800;
      7'd110: v = 48'h00f0c8c8c800;
      7'd111: v = 48'h0070c8c87000;
      7'd112: v = 48'h00f0c8c8f0c0;
      7'd113: v = 48'h007898987818;
      7'd114: v = 48'h00f0c8c0c000;
      7'd115: v = 48'h0078e038f000;
      7'd116: v = 48'h60f860603800;
      7'd117: v = 48'h009898987800;
      7'd118: v = 48'h00c8c8d0e000;
      7'd119: v = 48'h0088a8f8d800;
      7'd120: v = 48'h00d87070d800;
      7'd121: v = 48'h009898781870;
      7'd122: v = 48'h00f83060f800;
      7'd123: v = 48'h302060203000;
      7'd124: v = 48'h202020202000;
      7'd125: v = 48'h602030206000;
      7'd126: v = 48'h002850000000;
      default: v = 48'h000000000000;
    endcase
    return v;
  endfunction

  // One byte of the font store: glyph in the upper address bits, row below.
  function automatic logic [7:0] font_row(input logic [FONT_AW-1:0] a);
    logic [47:0] g;
    logic [7:0]  b;
    g = font_glyph(a[FONT_AW-1:ROW_W]);
    case (a[ROW_W-1:0])
      3'd0:    b = g[47:40];
      3'd1:    b = g[39:32];
      3'd2:    b = g[31:24];
      3'd3:    b = g[23:16];
      3'd4:    b = g[15:8];
      3'd5:    b = g[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/text_glyph_pixel_writer_top.sv -----
// Top level of the text glyph pixel writer: channels, configuration registers, instances.
//
// The block turns a stream of text characters into framebuffer pixel writes.
// Input channel (in_*): one transfer per character, carrying the code, the
// origin of a new string and the draw color; in_tuser set loads the origin
// into the cursor before the character is handled. Code 10 is a newline.
// Output channel (out_*): one transfer per set glyph pixel that lands on the
// screen, with the framebuffer word address and the color; out_tlast marks
// the final pixel of a character. Characters with no visible pixel give none.
// Configuration port (cfg_*): screen width, screen height and row pitch in
// words, written one per cycle by index; the user must make writes only while
// the block is idle, since the block itself does not enforce it. A newline
// moves the cursor without leaving the idle state. A drawn character passes
// through one font row fetch, the scan (one glyph bit per cycle while the
// receiver does not stall, as the output carries one pixel write per cycle)
// and a flush of the final pixel; since one pixel is held back to mark tlast,
// a pixel is registered to the output when the next visible pixel is found,
// and the final one in the flush state. When the receiver stalls, the scan
// pauses with one pixel in the output register and one held back. Reset
// returns the cursor and line start to zero, loads the default 320 by 240
// screen with a pitch of 320 words, and drops any pixel in flight.
module text_glyph_pixel_writer_top import tgpw_pkg::*; #(
  parameter int COORD_BITS = 12,
  localparam int IN_DW = ((2 * COORD_BITS + CODE_W + PIX_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // char_code, origin_x, origin_y, draw_color (lowest bits first), zero padded
  input  logic [IN_DW-1:0]  in_tdata,
  // start_string
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // pixel_address, pixel_value (lowest bits first)
  output logic [39:0]       out_tdata,
  output logic              out_tlast,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  cfg_regs_t          cfg_r, cfg_nxt;
  logic               rom_rd_en;
  logic [FONT_AW-1:0] rom_addr;
  logic [7:0]         rom_data;
  logic [ADDR_W-1:0]  pix_addr;
  logic [PIX_W-1:0]   pix_value;

  // Register writes; an index beyond the register list is dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_SCREEN_WIDTH:  cfg_nxt.screen_width    = cfg_wdata;
        REG_SCREEN_HEIGHT: cfg_nxt.screen_height   = cfg_wdata;
        REG_ROW_PITCH:     cfg_nxt.row_pitch_words = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width    <= RST_SCREEN_WIDTH;
      cfg_r.screen_height   <= RST_SCREEN_HEIGHT;
      cfg_r.row_pitch_words <= RST_ROW_PITCH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tgpw_font_rom u_font_rom (
    .clk     (clk),
    .rd_en   (rom_rd_en),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  tgpw_raster #(
    .COORD_BITS (COORD_BITS)
  ) u_raster (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_code     (in_tdata[CODE_W-1:0]),
    .in_start    (in_tuser),
    .in_origin_x (in_tdata[CODE_W +: COORD_BITS]),
    .in_origin_y (in_tdata[CODE_W + COORD_BITS +: COORD_BITS]),
    .in_color    (in_tdata[CODE_W + 2 * COORD_BITS +: PIX_W]),
    .rom_rd_en   (rom_rd_en),
    .rom_addr    (rom_addr),
    .rom_data    (rom_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_addr    (pix_addr),
    .out_value   (pix_value),
    .out_last    (out_tlast)
  );

  assign out_tdata = {pix_value, pix_addr};

endmodule

// ----- rtl/tgpw_font_rom.sv -----
// Font store: 128 glyphs of 8 row bytes, synchronous read into an output register.
module tgpw_font_rom import tgpw_pkg::*; (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [FONT_AW-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= font_row(rd_addr);
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/tgpw_raster.sv -----
// Cursor state, glyph row fetch, pixel scan and the output register.
module tgpw_raster import tgpw_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_regs_t             cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CODE_W-1:0]     in_code,
  input  logic                  in_start,
  input  logic [COORD_BITS-1:0] in_origin_x,
  input  logic [COORD_BITS-1:0] in_origin_y,
  input  logic [PIX_W-1:0]      in_color,
  output logic                  rom_rd_en,
  output logic [FONT_AW-1:0]    rom_addr,
  input  logic [7:0]            rom_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ADDR_W-1:0]     out_addr,
  output logic [PIX_W-1:0]      out_value,
  output logic                  out_last
);

  localparam int CW     = COORD_BITS + 2;
  localparam int CMPW   = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int PROD_W = CW + 1 + CFG_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [3:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + (CW+1)'(b);
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  state_t                state_r, state_nxt;
  logic [CW-1:0]         cur_col_r, cur_col_nxt;
  logic [CW-1:0]         cur_row_r, cur_row_nxt;
  logic [COORD_BITS-1:0] line_col_r, line_col_nxt;
  logic [CW-1:0]         draw_col_r, draw_col_nxt;
  logic [GLYPH_W-1:0]    glyph_r, glyph_nxt;
  logic                  flip_r, flip_nxt;
  logic [PIX_W-1:0]      color_r, color_nxt;
  logic [ROW_W-1:0]      row_idx_r, row_idx_nxt;
  logic [ROW_W-1:0]      bit_idx_r, bit_idx_nxt;
  logic                  row_ok_r, row_ok_nxt;
  logic [ADDR_W-1:0]     row_base_r, row_base_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic [ADDR_W-1:0]     pend_addr_r, pend_addr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]     out_addr_r, out_addr_nxt;
  logic [PIX_W-1:0]      out_value_r, out_value_nxt;
  logic                  out_last_r, out_last_nxt;

  // Row setup for the row whose byte is being fetched.
  logic                  setup_en;
  logic [ROW_W-1:0]      setup_idx;
  logic [CW+1:0]         row_ext;
  logic [CW:0]           row_val;
  logic [PROD_W-1:0]     row_prod;

  // Pixel candidate in the scan.
  logic [CW:0]           col_x;
  logic                  cand;
  logic [ADDR_W-1:0]     cand_addr;
  logic                  out_free;
  logic                  scan_adv;
  logic                  scan_done;

  // Origin loading applied before the character itself.
  logic [COORD_BITS-1:0] acc_line;
  logic [CW-1:0]         acc_col;
  logic [CW-1:0]         acc_row;

  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  assign acc_line = in_start ? in_origin_x : line_col_r;
  assign acc_col  = in_start ? CW'(in_origin_x) : cur_col_r;
  assign acc_row  = in_start ? CW'(in_origin_y) : cur_row_r;

  assign setup_idx = (state_r == S_FETCH) ? '0 : ROW_W'(row_idx_r + 3'd1);

  always_comb begin
    if (flip_r) begin
      row_ext = {2'b00, cur_row_r} + (CW+2)'(FLIP_BASE) - (CW+2)'(setup_idx);
    end else begin
      row_ext = {2'b00, cur_row_r} + (CW+2)'(setup_idx);
    end
  end

  assign row_val  = row_ext[CW:0];
  assign row_prod = row_val * cfg.row_pitch_words;

  assign col_x     = {1'b0, draw_col_r} + (CW+1)'(ROW_W'(LAST_BIT - bit_idx_r));
  assign cand      = row_ok_r && rom_data[bit_idx_r + 3'd2] &&
                     (CMPW'(col_x) < CMPW'(cfg.screen_width));
  assign cand_addr = row_base_r + ADDR_W'(col_x);
  assign scan_adv  = !(cand && pend_valid_r) || out_free;
  assign scan_done = (row_idx_r == LAST_ROW) && (bit_idx_r == LAST_BIT);

  assign setup_en = (state_r == S_FETCH) ||
                    ((state_r == S_SCAN) && scan_adv && (bit_idx_r == LAST_BIT) &&
                     (row_idx_r != LAST_ROW));

  assign rom_rd_en = setup_en;
  assign rom_addr  = {glyph_r, setup_idx};

  always_comb begin
    state_nxt      = state_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    line_col_nxt   = line_col_r;
    draw_col_nxt   = draw_col_r;
    glyph_nxt      = glyph_r;
    flip_nxt       = flip_r;
    color_nxt      = color_r;
    row_idx_nxt    = row_idx_r;
    bit_idx_nxt    = bit_idx_r;
    row_ok_nxt     = row_ok_r;
    row_base_nxt   = row_base_r;
    pend_valid_nxt = pend_valid_r;
    pend_addr_nxt  = pend_addr_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_addr_nxt   = out_addr_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;

    if (setup_en) begin
      row_idx_nxt  = setup_idx;
      row_ok_nxt   = !row_ext[CW+1] && (CMPW'(row_val) < CMPW'(cfg.screen_height));
      row_base_nxt = ADDR_W'(row_prod);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          line_col_nxt = acc_line;
          if (in_code == CHAR_NL) begin
            cur_col_nxt = CW'(acc_line);
            cur_row_nxt = sat_add(acc_row, LINE_H);
          end else begin
            cur_row_nxt  = acc_row;
            draw_col_nxt = acc_col;
            cur_col_nxt  = sat_add(acc_col, CELL_W);
            glyph_nxt    = in_code[GLYPH_W-1:0];
            flip_nxt     = in_code[CODE_W-1];
            color_nxt    = in_color;
            state_nxt    = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        bit_idx_nxt = '0;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        if (scan_adv) begin
          if (cand) begin
            pend_valid_nxt = 1'b1;
            pend_addr_nxt  = cand_addr;
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_addr_nxt  = pend_addr_r;
              out_value_nxt = color_r;
              out_last_nxt  = 1'b0;
            end
          end
          bit_idx_nxt = (bit_idx_r == LAST_BIT) ? '0 : ROW_W'(bit_idx_r + 3'd1);
          if (scan_done) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = pend_addr_r;
          out_value_nxt  = color_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      line_col_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_col_r    <= cur_col_nxt;
      cur_row_r    <= cur_row_nxt;
      line_col_r   <= line_col_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    draw_col_r  <= draw_col_nxt;
    glyph_r     <= glyph_nxt;
    flip_r      <= flip_nxt;
    color_r     <= color_nxt;
    row_idx_r   <= row_idx_nxt;
    bit_idx_r   <= bit_idx_nxt;
    row_ok_r    <= row_ok_nxt;
    row_base_r  <= row_base_nxt;
    pend_addr_r <= pend_addr_nxt;
    out_addr_r  <= out_addr_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_addr  = out_addr_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

`ifndef SYNTHESIS
  // A character never leaves a held-back pixel behind once it is finished.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_valid_r)
    else $error("pending pixel left over at end of character");

  // A pixel shown without the last mark always has a later pixel held back.
  a_notlast_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> pend_valid_r)
    else $error("non-final pixel on output with nothing pending");

  // Scan counters stay inside the 6 by 6 cell.
  a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ((row_idx_r <= LAST_ROW) && (bit_idx_r <= LAST_BIT)))
    else $error("scan counter outside the glyph cell");

  // A drawn character starts with a row fetch in the next cycle.
  a_draw_fetches: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_code != CHAR_NL)) |=> (state_r == S_FETCH))
    else $error("character transfer did not start a glyph fetch");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for text_glyph_pixel_writer_top: random character streams against a predictor.
`timescale 1ns / 1ps

module testbench;
  import tgpw_pkg::*;

  // The watchdog ends the run after this many cycles without any transfer.
  localparam int WATCHDOG_LIMIT = 2000;
  // A character that draws nothing still keeps the block busy through its fetch, scan and flush.
  localparam int DRAIN_CYCLES   = 48;
  localparam int CURSOR_MAX     = (1 << 14) - 1;
  localparam int FIRST_GLYPH    = 33;
  localparam int LAST_GLYPH     = 126;
  localparam logic [CFG_AW-1:0] REG_SPARE = 2'd3;
  localparam logic [7:0] FLIP_BIT = 8'h80;
  localparam logic [7:0] CHAR_NULL = 8'd0;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_DEL = 8'd127;

  // One character as the sender presents it.
  typedef struct packed {
    logic [7:0]  code;
    logic        start;
    logic [11:0] ox;
    logic [11:0] oy;
    logic [15:0] color;
  } char_item_t;

  // One framebuffer write as the block should produce it.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  color;
    logic              last;
  } pixel_write_t;

  // Glyph bitmaps for the printable codes, rows 0 to 5 with row 0 in the top byte.
  // Every other code of the lower half is a blank glyph.
  logic [47:0] glyph_rows [FIRST_GLYPH:LAST_GLYPH] = '{
    48'h303030003000, 48'h505000000000, 48'h50f850f85000, 48'h78a07028f000,
    48'h881020408800, 48'h40a068906800, 48'h204000000000, 48'h204040402000,
    48'h402020204000, 48'h20a870a82000, 48'h002070200000, 48'h000000602040,
    48'h000070000000, 48'h000000606000, 48'h081020408000, 48'h70c8c8c87000,
    48'h307030307800, 48'hf01870c0f800, 48'hf81830987000, 48'h3070d0f81000,
    48'hf8c0f018f000, 48'h70c0f0c87000, 48'hf8183060c000, 48'h70c870c87000,
    48'h70c878087000, 48'h606000606000, 48'h606000602040, 48'h102040201000,
    48'h007000700000, 48'h402010204000, 48'h781830003000, 48'h70a8b8807000,
    48'h70c8c8f8c800, 48'hf0c8f0c8f000, 48'h70c8c0c87000, 48'hf0c8c8c8f000,
    48'hf8c0f0c0f800, 48'hf8c0f0c0c000, 48'h78c0d8c87800, 48'hc8c8f8c8c800,
    48'h783030307800, 48'hf81818d87000, 48'hc8d0e0d0c800, 48'hc0c0c0c0f800,
    48'hd8f8f8a88800, 48'hc8e8f8d8c800, 48'h70c8c8c87000, 48'hf0c8c8f0c000,
    48'h70c8c8c87008, 48'hf0c8c8f0c800, 48'h78e07038f000, 48'h783030303000,
    48'hc8c8c8c87000, 48'hc8c8c8702000, 48'h88a8f8f8d800, 48'hc8c870c8c800,
    48'h686878303000, 48'hf83060c0f800, 48'h604040406000, 48'h804020100800,
    48'h602020206000, 48'h205088000000, 48'h000000007800, 48'h402000000000,
    48'h007898987800, 48'hc0f0c8c8f000, 48'h0078e0e07800, 48'h187898987800,
    48'h0070d8e07000, 48'h3860f8606000, 48'h007098f81870, 48'hc0f0c8c8c800,
    48'h300070307800, 48'h180018189870, 48'hc0c8f0c8c800, 48'h606060603800,
    48'h00d0f8a8a800, 48'h00f0c8c8c800, 48'h0070c8c87000, 48'h00f0c8c8f0c0,
    48'h007898987818, 48'h00f0c8c0c000, 48'h0078e038f000, 48'h60f860603800,
    48'h009898987800, 48'h00c8c8d0e000, 48'h0088a8f8d800, 48'h00d87070d800,
    48'h009898781870, 48'h00f83060f800, 48'h302060203000, 48'h202020202000,
    48'h602030206000, 48'h002850000000
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  // Characters waiting for the sender, and pixel writes the block still owes.
  char_item_t   char_q [$];
  pixel_write_t pixel_q [$];
  char_item_t   next_char;
  char_item_t   seen_char;
  pixel_write_t want;

  // Predictor state: cursor, line start and its copy of the screen registers.
  int cur_col;
  int cur_row;
  int line_col;
  int scr_w;
  int scr_h;
  int pitch;

  // When set, neither side inserts gaps.
  logic steady = 1'b0;

  int fail_count = 0;
  int chars_sent = 0;
  int pixels_checked = 0;
  int settings_used = 0;
  int quiet_cycles = 0;
  logic moved;

  text_glyph_pixel_writer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Cursor arithmetic saturates at the top of its 14-bit range.
  function automatic int bump(input int v, input int d);
    return (v + d > CURSOR_MAX) ? CURSOR_MAX : v + d;
  endfunction

  // Works out every pixel write one character causes and moves the cursor.
  task automatic predict_char(input char_item_t c);
    pixel_write_t hits [36];
    int n;
    int i;
    int b;
    longint r;
    longint xs;
    logic [47:0] bitmap;
    logic [7:0]  row_bits;
    logic [6:0]  g;
    n = 0;
    if (c.start) begin
      line_col = c.ox;
      cur_col = c.ox;
      cur_row = c.oy;
    end
    if (c.code == CHAR_NL) begin
      cur_col = line_col;
      cur_row = bump(cur_row, LINE_H);
      return;
    end
    g = c.code[6:0];
    bitmap = (g >= FIRST_GLYPH && g <= LAST_GLYPH) ? glyph_rows[g] : '0;
    for (i = 0; i < 6; i++) begin
      row_bits = bitmap[47 - 8 * i -: 8];
      // A flipped glyph is written bottom row first; rows above the screen are lost.
      r = c.code[7] ? longint'(cur_row) + FLIP_BASE - i : longint'(cur_row) + i;
      if (r < 0 || r >= scr_h) continue;
      // The scan runs from the rightmost drawn column leftward.
      for (b = 2; b < 8; b++) begin
        xs = longint'(cur_col) + 7 - b;
        if (!row_bits[b] || xs >= scr_w) continue;
        hits[n].addr = ADDR_W'(r * pitch + xs);
        hits[n].color = c.color;
        hits[n].last = 1'b0;
        n++;
      end
    end
    for (i = 0; i < n; i++) begin
      if (i == n - 1) hits[i].last = 1'b1;
      pixel_q.push_back(hits[i]);
    end
    cur_col = bump(cur_col, CELL_W);
  endtask

  // Sender: presents the next queued character once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (char_q.size() != 0 && (steady || $urandom_range(99) >= 15)) begin
        next_char = char_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {next_char.color, next_char.oy, next_char.ox, next_char.code};
        in_tuser <= next_char.start;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stalls at random unless a steady stretch is running.
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 15);
  end

  // Monitor: tracks register writes and accepted characters in the predictor,
  // checks each pixel transfer against the oldest expected write, and runs the
  // watchdog. Prediction comes first so ordering within an edge never matters.
  always @(posedge clk) begin
    if (!rst_n) begin
      cur_col = 0;
      cur_row = 0;
      line_col = 0;
      scr_w = RST_SCREEN_WIDTH;
      scr_h = RST_SCREEN_HEIGHT;
      pitch = RST_ROW_PITCH;
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (cfg_we) begin
        moved = 1'b1;
        case (cfg_addr)
          REG_SCREEN_WIDTH:  scr_w = cfg_wdata;
          REG_SCREEN_HEIGHT: scr_h = cfg_wdata;
          REG_ROW_PITCH:     pitch = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        seen_char.code = in_tdata[7:0];
        seen_char.ox = in_tdata[19:8];
        seen_char.oy = in_tdata[31:20];
        seen_char.color = in_tdata[47:32];
        seen_char.start = in_tuser;
        predict_char(seen_char);
        chars_sent++;
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        if (pixel_q.size() == 0) begin
          $error("pixel write with none expected: address %h value %h",
                 out_tdata[23:0], out_tdata[39:24]);
          fail_count++;
        end else begin
          want = pixel_q.pop_front();
          pixels_checked++;
          if (out_tdata[23:0] !== want.addr) begin
            $error("pixel_address: expected %h, got %h", want.addr, out_tdata[23:0]);
            fail_count++;
          end
          if (out_tdata[39:24] !== want.color) begin
            $error("pixel_value: expected %h, got %h", want.color, out_tdata[39:24]);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last_pixel: expected %b, got %b", want.last, out_tlast);
            fail_count++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d pixel writes outstanding",
                 quiet_cycles, pixel_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic queue_char(input logic [7:0] code, input logic start,
                            input logic [11:0] ox, input logic [11:0] oy,
                            input logic [15:0] color);
    char_item_t c;
    c.code = code;
    c.start = start;
    c.ox = ox;
    c.oy = oy;
    c.color = color;
    char_q.push_back(c);
  endtask

  // Waits for every queued character and expected write, then for the block
  // to finish a character that may draw nothing.
  task automatic settle();
    while (char_q.size() != 0 || in_tvalid || pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_screen(input int unsigned w, input int unsigned h, input int unsigned p);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    write_reg(REG_ROW_PITCH, p);
    settings_used++;
  endtask

  // Origins mostly land on or just past the visible area, sometimes anywhere.
  function automatic logic [11:0] pick_coord(input int span);
    if (span <= 0 || $urandom_range(99) < 20) return 12'($urandom_range(4095));
    return 12'($urandom_range((span + 8 > 4095) ? 4095 : span + 8));
  endfunction

  // Queues strings: a start character with an origin, then characters of
  // random content. A few strings lack the start flag and a few carry a
  // stray one in the middle.
  task automatic add_strings(input int n_items, input int col_span, input int row_span);
    int added;
    int len;
    int k;
    int pick;
    logic [7:0]  code;
    logic [11:0] ox;
    logic [11:0] oy;
    logic        start;
    added = 0;
    while (added < n_items) begin
      len = $urandom_range(8, 1);
      ox = pick_coord(col_span);
      oy = pick_coord(row_span);
      for (k = 0; k < len; k++) begin
        pick = $urandom_range(99);
        if (pick < 10) code = CHAR_NL;
        else if (pick < 25) code = FLIP_BIT | 8'($urandom_range(LAST_GLYPH, FIRST_GLYPH));
        else if (pick < 32) code = 8'($urandom_range(255));
        else code = 8'($urandom_range(LAST_GLYPH, FIRST_GLYPH));
        start = (k == 0) ? ($urandom_range(99) >= 5) : ($urandom_range(99) < 4);
        if (start && k != 0) begin
          ox = pick_coord(col_span);
          oy = pick_coord(row_span);
        end
        // Origin fields of characters without the start flag carry noise.
        queue_char(code, start, start ? ox : 12'($urandom), start ? oy : 12'($urandom),
                   16'($urandom));
      end
      added += len;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed characters on the default 320 by 240 screen.
    queue_char(8'd33, 1'b1, 12'd0, 12'd0, 16'hFFFF);
    queue_char(8'd65, 1'b0, 12'd0, 12'd0, 16'h0000);
    // Null, space and the unused top code draw nothing but still advance.
    queue_char(CHAR_NULL, 1'b0, 12'hFFF, 12'hFFF, 16'h1111);
    queue_char(CHAR_SPACE, 1'b0, 12'd0, 12'd0, 16'h2222);
    queue_char(CHAR_DEL, 1'b0, 12'd0, 12'd0, 16'h3333);
    queue_char(CHAR_NL, 1'b0, 12'd0, 12'd0, 16'h4444);
    // Upside-down glyphs, including blank ones.
    queue_char(FLIP_BIT | 8'd65, 1'b0, 12'd0, 12'd0, 16'hA5A5);
    queue_char(8'd255, 1'b0, 12'd0, 12'd0, 16'h5555);
    queue_char(FLIP_BIT, 1'b0, 12'd0, 12'd0, 16'h6666);
    // Flipped glyphs at row 0 lose the row that would lie above the screen.
    queue_char(FLIP_BIT | 8'd81, 1'b1, 12'd0, 12'd0, 16'h5A5A);
    queue_char(FLIP_BIT | 8'd103, 1'b0, 12'd0, 12'd0, 16'h8001);
    // Right and bottom clipping, then characters fully off screen.
    queue_char(8'd87, 1'b1, 12'd316, 12'd236, 16'h7E7E);
    queue_char(8'd77, 1'b0, 12'd0, 12'd0, 16'h00FF);
    queue_char(8'd72, 1'b1, 12'hFFF, 12'hFFF, 16'hFF00);
    queue_char(CHAR_NL, 1'b0, 12'd0, 12'd0, 16'h0001);
    queue_char(8'd35, 1'b1, 12'd0, 12'd232, 16'hC3C3);
    queue_char(8'd106, 1'b0, 12'd0, 12'd0, 16'h3C3C);
    // A newline that also starts a string moves down from the new origin.
    queue_char(CHAR_NL, 1'b1, 12'd10, 12'd20, 16'h0000);
    queue_char(8'd66, 1'b0, 12'd0, 12'd0, 16'h1234);
    queue_char(FLIP_BIT | 8'd66, 1'b1, 12'd314, 12'd0, 16'h8000);
    settle();

    add_strings(40, 320, 240);
    settle();

    // Smallest screen and pitch: only pixel 0,0 is visible.
    set_screen(1, 1, 1);
    queue_char(8'd66, 1'b1, 12'd0, 12'd0, 16'hBEEF);
    queue_char(FLIP_BIT | 8'd66, 1'b1, 12'd0, 12'd0, 16'hCAFE);
    add_strings(18, 1, 1);
    settle();

    // A zero width and height clip everything; the spare index is ignored.
    set_screen(0, 0, 4096);
    write_reg(REG_SPARE, 13'h1FFF);
    add_strings(10, 16, 16);
    settle();

    // Largest register values: addresses wrap at 24 bits.
    set_screen(8191, 8191, 8191);
    add_strings(30, 4095, 4095);
    settle();

    // Both sides run without gaps through this stretch.
    set_screen(4096, 4096, 4096);
    steady = 1'b1;
    add_strings(40, 4095, 4095);
    settle();
    steady = 1'b0;

    set_screen($urandom_range(4096, 1), $urandom_range(4096, 1), $urandom_range(4096, 1));
    add_strings(25, 400, 300);
    settle();

    // Far corner of the coordinate range on the widest screen, where the
    // cursor runs past the largest origin and addresses wrap.
    set_screen(8191, 8191, 8191);
    queue_char(8'd72, 1'b1, 12'd4090, 12'd4090, 16'h0F0F);
    queue_char(CHAR_NL, 1'b0, 12'd0, 12'd0, 16'h0000);
    queue_char(8'd72, 1'b0, 12'd0, 12'd0, 16'hF0F0);
    queue_char(FLIP_BIT | 8'd72, 1'b0, 12'd0, 12'd0, 16'hF0F0);
    queue_char(CHAR_NL, 1'b0, 12'd0, 12'd0, 16'h0000);
    queue_char(8'd87, 1'b0, 12'd0, 12'd0, 16'hF00F);
    queue_char(8'd72, 1'b1, 12'd100, 12'd100, 16'h0FF0);
    settle();

    $display("Summary: %0d characters over %0d screen settings plus the default screen,",
             chars_sent, settings_used);
    $display("         %0d pixel writes compared, %0d mismatches.", pixels_checked, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tgpw_pkg.sv
rtl/tgpw_font_rom.sv
rtl/tgpw_raster.sv
rtl/text_glyph_pixel_writer_top.sv
tb/testbench.sv
